// ----- design/scsa_pkg.sv -----
`timescale 1ns / 1ps

package scsa_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 40;
    localparam int MIN_SHIFT    = 3;
    localparam int NUM_CLASSES  = 9;

    localparam int SIZE_W    = 16;
    localparam int OFF_W     = 12;
    localparam int CLS_W     = 4;
    localparam int LINK_W    = 10;
    localparam int MAX_SLOTS = PAGE_BYTES >> MIN_SHIFT;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int MEM_DEPTH = NUM_CLASSES * MAX_SLOTS;
    localparam int MEM_AW    = CLS_W + SLOT_W;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] request_size;
        logic              address_present;
        logic [OFF_W-1:0]  address_offset;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [CLS_W-1:0] size_class;
        logic [OFF_W-1:0] result_offset;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic eval;
        logic build_step;
        logic read_done;
        logic deliver;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_build;
        logic need_read;
        logic build_last;
        logic out_free;
    } ctl_status_t;

    // Smallest class whose object size covers the request; NUM_CLASSES if none does.
    function automatic logic [CLS_W-1:0] pick_class(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] k;
        k = CLS_W'(NUM_CLASSES);
        for (int j = NUM_CLASSES - 1; j >= 0; j--) begin
            if ({1'b0, size} <= ((SIZE_W + 1)'(1) << (j + MIN_SHIFT))) begin
                k = CLS_W'(j);
            end
        end
        return k;
    endfunction

    function automatic logic [LINK_W-1:0] slot_count(input logic [CLS_W-1:0] k);
        return LINK_W'((PAGE_BYTES - HEADER_BYTES) >> (int'(k) + MIN_SHIFT));
    endfunction

endpackage

// ----- design/scsa_ctrl.sv -----
`timescale 1ns / 1ps

module scsa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  scsa_pkg::ctl_status_t st,
    output scsa_pkg::ctl_cmd_t    cmd,
    output logic                  req_stall
);
    import scsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_BUILD = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_req = req_valid;
                if (req_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (st.need_build) begin
                    state_next = S_BUILD;
                end else if (st.need_read) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BUILD: begin
                cmd.build_step = 1'b1;
                // Once the chain is complete the request is decided afresh.
                if (st.build_last) begin
                    state_next = S_EVAL;
                end
            end
            S_READ: begin
                cmd.read_done = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                cmd.deliver = st.out_free;
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    a_build_returns_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD && st.build_last) |=> (state_reg == S_EVAL))
        else $error("chain build did not hand back to evaluation");

endmodule

// ----- design/scsa_datapath.sv -----
`timescale 1ns / 1ps

module scsa_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scsa_pkg::req_t        req,
    input  logic                  rsp_stall,
    input  scsa_pkg::ctl_cmd_t    cmd,
    output scsa_pkg::ctl_status_t st,
    output logic                  rsp_valid,
    output scsa_pkg::rsp_t        rsp
);
    import scsa_pkg::*;

    req_t               req_reg;
    rsp_t               res_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;
    logic [SLOT_W-1:0]  build_cnt_reg;
    logic [SLOT_W-1:0]  build_cnt_next;
    logic [NUM_CLASSES-1:0] built_reg;
    logic [LINK_W-1:0]  head_reg [NUM_CLASSES];
    logic [LINK_W-1:0]  link_mem [MEM_DEPTH];
    logic [LINK_W-1:0]  rd_data_reg;

    logic [CLS_W-1:0]   k_raw;
    logic               in_range;
    logic [CLS_W-1:0]   cls;
    logic [LINK_W-1:0]  count;
    logic               has_slots;
    logic [LINK_W-1:0]  head;
    logic               built;
    logic [CLS_W-1:0]   sh;
    logic [OFF_W-1:0]   rel_off;
    logic [OFF_W-1:0]   mask;
    logic [OFF_W-1:0]   slot_d;
    logic               addr_bad;
    logic               is_free;
    logic               do_push;
    status_t            imm_status;
    logic [CLS_W-1:0]   imm_class;
    logic [OFF_W-1:0]   alloc_offset;
    logic               mem_we;
    logic               mem_re;
    logic [SLOT_W-1:0]  mem_slot;
    logic [MEM_AW-1:0]  mem_addr;
    logic [LINK_W-1:0]  mem_wdata;

    always_ff @(posedge clk) begin
        if (cmd.load_req) begin
            req_reg <= req;
        end
    end

    assign is_free   = req_reg.command;
    assign k_raw     = pick_class(req_reg.request_size);
    assign in_range  = (k_raw < CLS_W'(NUM_CLASSES));
    assign cls       = in_range ? k_raw : '0;
    assign count     = slot_count(cls);
    assign has_slots = (count != '0);
    assign head      = head_reg[cls];
    assign built     = built_reg[cls];
    assign sh        = cls + CLS_W'(MIN_SHIFT);

    // Free address checks: past the header, on a slot boundary, inside the page.
    assign rel_off  = req_reg.address_offset - OFF_W'(HEADER_BYTES);
    assign mask     = ~({OFF_W{1'b1}} << sh);
    assign slot_d   = rel_off >> sh;
    assign addr_bad = (req_reg.address_offset < OFF_W'(HEADER_BYTES))
                   || ((rel_off & mask) != '0)
                   || (slot_d >= OFF_W'(count));

    assign alloc_offset = OFF_W'(HEADER_BYTES) + (OFF_W'(head[SLOT_W-1:0]) << sh);

    assign build_cnt_next = build_cnt_reg + SLOT_W'(1);

    always_comb begin
        imm_status    = ST_OK;
        imm_class     = cls;
        do_push       = 1'b0;
        st.need_build = 1'b0;
        st.need_read  = 1'b0;
        st.build_last = ({1'b0, build_cnt_reg} == (count - LINK_W'(1)));
        st.out_free   = !rsp_valid_reg || !rsp_stall;
        priority if (is_free && !req_reg.address_present) begin
            imm_status = ST_IGNORED;
            imm_class  = '0;
        end else if (!in_range || !has_slots) begin
            imm_status = ST_TOO_LARGE;
            imm_class  = '0;
        end else if (!is_free) begin
            if (!built) begin
                st.need_build = 1'b1;
            end else if (head >= count) begin
                imm_status = ST_EXHAUSTED;
            end else begin
                st.need_read = 1'b1;
            end
        end else if (!built) begin
            imm_status = ST_IGNORED;
        end else if (addr_bad) begin
            imm_status = ST_BAD_ADDR;
        end else begin
            do_push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            build_cnt_reg <= '0;
        end else if (cmd.load_req) begin
            build_cnt_reg <= '0;
        end else if (cmd.build_step) begin
            build_cnt_reg <= build_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            built_reg <= '0;
        end else if (cmd.build_step && st.build_last) begin
            built_reg[cls] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.build_step && st.build_last) begin
            head_reg[cls] <= '0;
        end else if (cmd.eval && do_push) begin
            head_reg[cls] <= LINK_W'(slot_d[SLOT_W-1:0]);
        end else if (cmd.read_done) begin
            head_reg[cls] <= rd_data_reg;
        end
    end

    // One port: the chain build and a push write, a pop reads the head's link.
    assign mem_we    = cmd.build_step || (cmd.eval && do_push);
    assign mem_re    = cmd.eval && st.need_read;
    assign mem_slot  = cmd.build_step ? build_cnt_reg
                     : (do_push ? slot_d[SLOT_W-1:0] : head[SLOT_W-1:0]);
    assign mem_addr  = {cls, mem_slot};
    assign mem_wdata = cmd.build_step ? (LINK_W'(build_cnt_reg) + LINK_W'(1)) : head;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            link_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.read_done) begin
            res_reg.status        <= ST_OK;
            res_reg.size_class    <= cls;
            res_reg.result_offset <= alloc_offset;
        end else if (cmd.eval && !st.need_build) begin
            res_reg.status        <= imm_status;
            res_reg.size_class    <= imm_class;
            res_reg.result_offset <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (cmd.deliver) begin
            rsp_valid_reg <= 1'b1;
        end else if (!rsp_stall) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.deliver) begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_head_in_class: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg[cls] |-> (head_reg[cls] <= slot_count(cls)))
        else $error("free list head left its class");

    a_offset_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.result_offset != '0) |->
            (rsp_reg.status == ST_OK && rsp_reg.result_offset >= OFF_W'(HEADER_BYTES)))
        else $error("offset reported outside a successful alloc");

    a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.size_class < CLS_W'(NUM_CLASSES)))
        else $error("reported class out of range");

endmodule

// ----- design/size_class_slab_allocator_unit.sv -----
`timescale 1ns / 1ps
// Channel   Handshake              Payload          Moves
// request   req_valid / req_stall  req  (req_t)     alloc or free request in
// response  rsp_valid / rsp_stall  rsp  (rsp_t)     one result per request out
//
// One request at a time: a free or an immediate result passes from the evaluation
// state through the done state into the response register before the next request
// is taken; a pop from a built class also passes through the read state (the link
// memory read is registered). The first alloc of a class first chains its slots,
// one link memory write per cycle, then decides again.
// Reset clears the state, built flags, build counter and response valid; list heads
// and links are written before use. A waiting response does not block the next request
// being taken; a stalled response holds the finished result until the output register frees.
module size_class_slab_allocator_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  scsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scsa_pkg::rsp_t rsp
);
    import scsa_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t st;

    scsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .st        (st),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    scsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- tb/sv/tb_size_class_slab_allocator_unit.sv -----
`timescale 1ns / 1ps

module tb_size_class_slab_allocator_unit;
    import scsa_pkg::*;

    localparam logic CMD_ALLOC      = 1'b0;
    localparam logic CMD_FREE       = 1'b1;
    localparam int   RANDOM_TARGET  = 900;
    localparam int   QUIET_LIMIT    = 4000;
    localparam int   SETTLE_CYCLES  = 20;
    localparam int   STALL_PERCENT  = 26;

    typedef struct {
        req_t payload;
        bit   drain_first;
    } pending_req_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    pending_req_t queued_requests[$];
    rsp_t         owed_results[$];

    int accepted_n  = 0;
    int delivered_n = 0;
    int fail_n      = 0;
    int quiet_n     = 0;

    // Shadow allocator state.
    bit class_built[NUM_CLASSES];
    int free_head[NUM_CLASSES];
    int next_link[NUM_CLASSES][MAX_SLOTS];

    // A stretch with no random idling on either side.
    wire calm = (accepted_n >= 400) && (accepted_n < 550);

    size_class_slab_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    function automatic int class_slots(input int k);
        return (PAGE_BYTES - HEADER_BYTES) >> (k + MIN_SHIFT);
    endfunction

    function automatic int class_size(input int k);
        if (k == 0)
        begin
            return $urandom_range(0, 8);
        end
        return $urandom_range((1 << (k + MIN_SHIFT - 1)) + 1, 1 << (k + MIN_SHIFT));
    endfunction

    function automatic int slot_address(input int k, input int slot);
        return HEADER_BYTES + slot * (1 << (k + MIN_SHIFT));
    endfunction

    function automatic req_t make_req(input logic cmd, input int size, input logic present,
                                      input int off);
        req_t r;
        r.command         = cmd;
        r.request_size    = SIZE_W'(size);
        r.address_present = present;
        r.address_offset  = OFF_W'(off);
        return r;
    endfunction

    task automatic queue_request(input req_t r);
        pending_req_t p;
        p.payload     = r;
        // Now and then the sender holds off until every response is back.
        p.drain_first = (queued_requests.size() % 150) == 30;
        queued_requests.push_back(p);
    endtask

    // Applies one request to the shadow allocator and returns its response.
    function automatic rsp_t slab_apply(input req_t r);
        rsp_t o;
        int   k;
        int   cnt;
        int   obj;
        int   slot;
        int   addr;
        o = '0;
        if (r.command == CMD_FREE && !r.address_present)
        begin
            o.status = ST_IGNORED;
            return o;
        end
        k = 0;
        while (k < NUM_CLASSES && (1 << (k + MIN_SHIFT)) < int'(r.request_size))
        begin
            k++;
        end
        cnt = (k < NUM_CLASSES) ? class_slots(k) : 0;
        if (cnt == 0)
        begin
            o.status = ST_TOO_LARGE;
            return o;
        end
        obj          = 1 << (k + MIN_SHIFT);
        addr         = int'(r.address_offset);
        o.size_class = CLS_W'(k);
        if (r.command == CMD_ALLOC)
        begin
            if (!class_built[k])
            begin
                for (int s = 0; s < cnt; s++)
                begin
                    next_link[k][s] = s + 1;
                end
                free_head[k]   = 0;
                class_built[k] = 1'b1;
            end
            if (free_head[k] >= cnt)
            begin
                o.status = ST_EXHAUSTED;
            end
            else
            begin
                slot            = free_head[k];
                free_head[k]    = next_link[k][slot];
                o.result_offset = OFF_W'(HEADER_BYTES + slot * obj);
            end
        end
        else if (!class_built[k])
        begin
            o.status = ST_IGNORED;
        end
        else if (addr < HEADER_BYTES || (addr - HEADER_BYTES) % obj != 0
                 || (addr - HEADER_BYTES) / obj >= cnt)
        begin
            o.status = ST_BAD_ADDR;
        end
        else
        begin
            slot               = (addr - HEADER_BYTES) / obj;
            next_link[k][slot] = free_head[k];
            free_head[k]       = slot;
        end
        return o;
    endfunction

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        fail_n++;
        if (fail_n <= 10)
        begin
            $display("%0t %s: expected status=%0d class=%0d offset=%0d", $realtime, what,
                     want.status, want.size_class, want.result_offset);
            $display("%0t %s: actual   status=%0d class=%0d offset=%0d", $realtime, what,
                     got.status, got.size_class, got.result_offset);
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            accepted_n <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                accepted_n <= accepted_n + 1;
            end
            if (queued_requests.size() != 0
                && !(queued_requests[0].drain_first
                     && (req_valid || accepted_n != delivered_n))
                && (calm || $urandom_range(0, 99) >= STALL_PERCENT))
            begin
                req       <= queued_requests[0].payload;
                req_valid <= 1'b1;
                void'(queued_requests.pop_front());
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and scoreboard.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall   <= 1'b0;
            delivered_n <= 0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                class_built[c] = 1'b0;
            end
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                delivered_n <= delivered_n + 1;
                if (owed_results.size() == 0)
                begin
                    note_failure("response with no request owed", '0, rsp);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp.status !== want.status || rsp.size_class !== want.size_class
                        || rsp.result_offset !== want.result_offset)
                    begin
                        note_failure("response mismatch", want, rsp);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                owed_results.push_back(slab_apply(req));
            end
            rsp_stall <= !calm && ($urandom_range(0, 99) < STALL_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_n <= 0;
        end
        else if (quiet_n == QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_n <= quiet_n + 1;
        end
    end

    initial
    begin
        int k;
        int cnt;
        int roll;
        int total;
        total = 0;

        // Directed requests.
        queue_request(make_req(CMD_FREE, 65535, 1'b0, 4095));
        queue_request(make_req(CMD_FREE, 0, 1'b1, HEADER_BYTES));
        queue_request(make_req(CMD_ALLOC, 0, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 8, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 9, 1'b1, 4095));
        queue_request(make_req(CMD_ALLOC, 2048, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 2047, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 2049, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 65535, 1'b1, 4095));
        queue_request(make_req(CMD_FREE, 4096, 1'b1, HEADER_BYTES));
        queue_request(make_req(CMD_FREE, 1, 1'b1, 0));
        queue_request(make_req(CMD_FREE, 1, 1'b1, HEADER_BYTES + 1));
        queue_request(make_req(CMD_FREE, 2048, 1'b1, slot_address(8, 1)));
        queue_request(make_req(CMD_FREE, 2048, 1'b1, HEADER_BYTES));
        queue_request(make_req(CMD_ALLOC, 1500, 1'b0, 0));
        // The same slot freed twice is handed out by each of the three allocs that follow.
        queue_request(make_req(CMD_FREE, 8, 1'b1, slot_address(0, 1)));
        queue_request(make_req(CMD_FREE, 8, 1'b1, slot_address(0, 1)));
        queue_request(make_req(CMD_ALLOC, 8, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 8, 1'b0, 0));
        queue_request(make_req(CMD_ALLOC, 8, 1'b0, 0));
        queue_request(make_req(CMD_FREE, 8, 1'b1, slot_address(0, class_slots(0) - 1)));
        queue_request(make_req(CMD_ALLOC, 4, 1'b0, 0));
        queue_request(make_req(CMD_FREE, 16, 1'b1, HEADER_BYTES));
        queue_request(make_req(CMD_FREE, 32, 1'b1, HEADER_BYTES));

        while (total < RANDOM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, NUM_CLASSES - 1);
            cnt  = class_slots(k);
            if (roll < 8)
            begin
                queue_request(make_req(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                                       1'($urandom_range(0, 1)), $urandom_range(0, 4095)));
                total++;
            end
            else if (roll < 11)
            begin
                // Run one of the larger classes (fewest slots) dry, then hand some slots back.
                k   = $urandom_range(4, NUM_CLASSES - 1);
                cnt = class_slots(k);
                for (int j = 0; j < cnt + 2; j++)
                begin
                    queue_request(make_req(CMD_ALLOC, class_size(k), 1'b0, 0));
                    total++;
                end
                for (int j = 0; j < cnt; j++)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        queue_request(make_req(CMD_FREE, class_size(k), 1'b1,
                                               slot_address(k, j)));
                        total++;
                    end
                end
            end
            else if (roll < 55)
            begin
                queue_request(make_req(CMD_ALLOC, class_size(k), 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 4095)));
                total++;
            end
            else if (roll < 60)
            begin
                queue_request(make_req(CMD_FREE, $urandom_range(0, 65535), 1'b0,
                                       $urandom_range(0, 4095)));
                total++;
            end
            else if (roll < 68)
            begin
                queue_request(make_req(CMD_FREE, class_size(k), 1'b1,
                                       $urandom_range(0, 4095)));
                total++;
            end
            else
            begin
                // Slots near the head of the list are the ones most likely in use.
                if ($urandom_range(0, 1) == 1)
                begin
                    cnt = (cnt > 16) ? 16 : cnt;
                end
                queue_request(make_req(CMD_FREE, class_size(k), 1'b1,
                                       slot_address(k, $urandom_range(0, cnt - 1))));
                total++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (queued_requests.size() != 0 || req_valid || owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_n == 0 && owed_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- size_class_slab_allocator_unit.f -----
design/scsa_pkg.sv
design/scsa_ctrl.sv
design/scsa_datapath.sv
design/size_class_slab_allocator_unit.sv
tb/sv/tb_size_class_slab_allocator_unit.sv
